@@ design/ufs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// UTF-8 structural filter package
// Shared constants, the job type passed from front to back, and lead decode.
// ============================================================================
package ufs_pkg;

    localparam int unsigned JOB_BYTES = 4;
    localparam int unsigned JOB_DEPTH = 4;
    localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    typedef logic [1:0] t_idx;

    typedef struct packed {
        t_idx                       last_idx;
        logic [JOB_BYTES-1:0][7:0]  bytes;
    } t_job;

    function automatic logic [1:0] lead_need(input logic [7:0] b);
        logic [1:0] need;
        need = NEED_NONE;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            need = NEED_ONE;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            need = NEED_TWO;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            need = NEED_THREE;
        end
        return need;
    endfunction

endpackage
`default_nettype wire

@@ design/ufs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// UTF-8 filter front end
// Classifies each byte, holds a pending sequence and emits complete jobs.
// ============================================================================
module ufs_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_byte,
    output ufs_pkg::t_job     o_job,
    output logic              o_job_valid
);

    logic [7:0] r_held [3];
    logic [7:0] n_held [3];
    logic [1:0] r_held_cnt;
    logic [1:0] n_held_cnt;
    logic [1:0] r_need;
    logic [1:0] n_need;
    logic       is_cont;
    logic [1:0] lead;

    always_comb begin
        n_held      = r_held;
        n_held_cnt  = r_held_cnt;
        n_need      = r_need;
        o_job_valid = 1'b0;
        o_job.bytes    = {i_byte, r_held[2], r_held[1], r_held[0]};
        o_job.last_idx = r_held_cnt;
        is_cont     = (i_byte & ufs_pkg::CONT_MASK) == ufs_pkg::CONT_CODE;
        lead        = ufs_pkg::lead_need(i_byte);
        if (i_accept) begin
            if (r_need != ufs_pkg::NEED_NONE && is_cont) begin
                if (r_held_cnt >= r_need) begin
                    o_job_valid = 1'b1;
                    o_job.bytes[r_held_cnt] = i_byte;
                    n_held_cnt = 2'd0;
                    n_need     = ufs_pkg::NEED_NONE;
                end else begin
                    case (r_held_cnt)
                        2'd1: begin
                            n_held[1] = i_byte;
                        end
                        2'd2: begin
                            n_held[2] = i_byte;
                        end
                        default: begin
                            n_held[0] = i_byte;
                        end
                    endcase
                    n_held_cnt = r_held_cnt + 2'd1;
                end
            end else if (!i_byte[7]) begin
                o_job_valid    = 1'b1;
                o_job.bytes[0] = i_byte;
                o_job.last_idx = 2'd0;
                n_held_cnt     = 2'd0;
                n_need         = ufs_pkg::NEED_NONE;
            end else if (lead != ufs_pkg::NEED_NONE) begin
                n_held[0]  = i_byte;
                n_held_cnt = 2'd1;
                n_need     = lead;
            end else begin
                n_held_cnt = 2'd0;
                n_need     = ufs_pkg::NEED_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_need     <= ufs_pkg::NEED_NONE;
        end else begin
            r_held_cnt <= n_held_cnt;
            r_need     <= n_need;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_need == ufs_pkg::NEED_NONE |-> r_held_cnt == 2'd0)
        else $error("held bytes without a pending sequence");
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_need != ufs_pkg::NEED_NONE |-> r_held_cnt != 2'd0 && r_held_cnt <= r_need)
        else $error("held count out of range for pending sequence");
`endif

endmodule
`default_nettype wire

@@ design/ufs_job_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// UTF-8 filter job queue
// Short queue of complete jobs between the front end and the output stage.
// ============================================================================
module ufs_job_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ufs_pkg::t_job  i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output ufs_pkg::t_job       o_job
);

    ufs_pkg::t_job                   r_mem [ufs_pkg::JOB_DEPTH];
    logic [ufs_pkg::JOB_PTR_W-1:0]   r_wr_ptr;
    logic [ufs_pkg::JOB_PTR_W-1:0]   r_rd_ptr;
    logic [ufs_pkg::JOB_CNT_W-1:0]   r_count;
    logic [ufs_pkg::JOB_CNT_W-1:0]   n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = r_count == ufs_pkg::JOB_CNT_W'(ufs_pkg::JOB_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + ufs_pkg::JOB_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - ufs_pkg::JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + ufs_pkg::JOB_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + ufs_pkg::JOB_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ufs_pkg::JOB_CNT_W'(ufs_pkg::JOB_DEPTH))
        else $error("job queue count out of range");
`endif

endmodule
`default_nettype wire

@@ design/ufs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// UTF-8 filter output stage
// Takes jobs from the queue and presents their bytes one per transfer.
// ============================================================================
module ufs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_empty,
    input  wire ufs_pkg::t_job  i_job,
    output logic                o_job_pop,
    output logic                o_empty,
    input  wire logic           i_pop,
    output logic [7:0]          o_byte,
    output logic                o_last
);

    logic           r_busy;
    ufs_pkg::t_job  r_job;
    ufs_pkg::t_idx  r_idx;
    logic           out_pop;

    assign o_empty   = !r_busy;
    assign o_last    = r_idx == r_job.last_idx;
    assign o_byte    = r_job.bytes[r_idx];
    assign out_pop   = i_pop && r_busy;
    assign o_job_pop = !i_job_empty && (!r_busy || (out_pop && o_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_job_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_pop) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= r_job.last_idx)
        else $error("byte index beyond end of job");
`endif

endmodule
`default_nettype wire

@@ design/utf8_structural_filter.sv @@
// An ASCII byte or the byte that completes a sequence is written into the job
// queue and then loaded into the output stage's job register on its way to the
// result ports. One byte per cycle on both sides, while full is low at the
// input and empty is low at the output; a four-entry job queue absorbs bursts.
// Reset: synchronous and active low; clears pending state, queue and output.
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// UTF-8 structural filter
// Passes only structurally well-formed UTF-8 sequences from a byte stream.
// ============================================================================
module utf8_structural_filter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last
);

    ufs_pkg::t_job  front_job;
    logic           front_job_valid;
    ufs_pkg::t_job  queue_job;
    logic           queue_empty;
    logic           queue_pop;
    logic           accept;

    assign accept = push && !full;

    ufs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_in_byte),
        .o_job       (front_job),
        .o_job_valid (front_job_valid)
    );

    ufs_job_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_job_valid),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_job   (queue_job)
    );

    ufs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (queue_empty),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_byte      (o_out_byte),
        .o_last      (o_run_last)
    );

endmodule
`default_nettype wire
